>>> rtl/pi_pkg.sv
// Package for the interpolated percentile block: sizes, FSM state and
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package pi_pkg;
  localparam int SAMPLE_W = 32;
  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int FRAC_W   = 17;
  localparam int Q_W      = 16;
  localparam int USED_W   = 11;

  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEEK, ST_CMP, ST_CALC, ST_RDLO, ST_RDHI, ST_TAKEHI, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;     // capture sample, start insert at the tail
    logic drop;     // store full, mark overflow
    logic rd_prev;  // read entry below insert point
    logic shift;    // move read entry up one place
    logic place;    // write sample at insert point
    logic calc;     // position, neighbour indexes, fraction
    logic rd_lo;
    logic rd_hi;
    logic take_lo;
    logic take_hi;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic greater;
    logic last;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/pi_sample_if.sv
// Input channel: one sample per transaction with an end-of-set flag.
// Depends on pi_pkg.
`default_nettype none
interface pi_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [pi_pkg::SAMPLE_W-1:0] sample_value;
  logic                             last_sample;
  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink (input valid, input sample_value, input last_sample, output ready);
endinterface
`default_nettype wire

>>> rtl/pi_result_if.sv
// Output channel: one percentile result per set.
// Depends on pi_pkg.
`default_nettype none
interface pi_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pi_pkg::SAMPLE_W-1:0] percentile_value;
  logic [pi_pkg::USED_W-1:0]          samples_used;
  logic                               overflow_seen;
  modport source (output valid, output percentile_value, output samples_used,
                  output overflow_seen, input ready);
  modport sink (input valid, input percentile_value, input samples_used,
                input overflow_seen, output ready);
endinterface
`default_nettype wire

>>> rtl/pi_ctrl.sv
// Controller FSM: sorted insertion walk and interpolation sequence.
// Depends on pi_pkg.
`default_nettype none
module pi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire pi_pkg::sts_t  sts,
  output pi_pkg::cmd_t       cmd
);
  pi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pi_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.full) begin
            cmd.drop = 1'b1;
            if (in_last) state_next = pi_pkg::ST_CALC;
          end else begin
            state_next = pi_pkg::ST_SEEK;
          end
        end
      end
      pi_pkg::ST_SEEK: begin
        if (sts.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = sts.last ? pi_pkg::ST_CALC : pi_pkg::ST_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = pi_pkg::ST_CMP;
        end
      end
      pi_pkg::ST_CMP: begin
        if (sts.greater) begin
          cmd.shift  = 1'b1;
          state_next = pi_pkg::ST_SEEK;
        end else begin
          cmd.place  = 1'b1;
          state_next = sts.last ? pi_pkg::ST_CALC : pi_pkg::ST_IDLE;
        end
      end
      pi_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = pi_pkg::ST_RDLO;
      end
      pi_pkg::ST_RDLO: begin
        cmd.rd_lo  = 1'b1;
        state_next = pi_pkg::ST_RDHI;
      end
      pi_pkg::ST_RDHI: begin
        cmd.take_lo = 1'b1;
        cmd.rd_hi   = 1'b1;
        state_next  = pi_pkg::ST_TAKEHI;
      end
      pi_pkg::ST_TAKEHI: begin
        cmd.take_hi = 1'b1;
        state_next  = pi_pkg::ST_MUL;
      end
      pi_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = pi_pkg::ST_EMIT;
      end
      pi_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = pi_pkg::ST_IDLE;
        end
      end
      default: state_next = pi_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/pi_dp.sv
// Datapath: sorted sample memory, insert pointer, interpolation arithmetic
// and the result register. Depends on pi_pkg.
`default_nettype none
module pi_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pi_pkg::cmd_t                       cmd,
  output pi_pkg::sts_t                            sts,
  input  wire logic signed [pi_pkg::SAMPLE_W-1:0] in_value,
  input  wire logic                               in_last,
  input  wire logic                               cfg_we,
  input  wire logic [pi_pkg::FRAC_W-1:0]          cfg_wdata,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pi_pkg::SAMPLE_W-1:0]      out_value,
  output logic [pi_pkg::USED_W-1:0]               out_used,
  output logic                                    out_ovf
);
  localparam int SW = pi_pkg::SAMPLE_W;
  localparam int AW = pi_pkg::ADDR_W;
  localparam int CW = pi_pkg::CNT_W;
  localparam int FW = pi_pkg::FRAC_W;
  localparam int QW = pi_pkg::Q_W;
  localparam int PW = AW + FW;

  logic signed [SW-1:0] mem [pi_pkg::DEPTH];
  logic signed [SW-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic signed [SW-1:0] wr_data;
  logic                 wr_en;

  logic [FW-1:0]        frac_cfg;
  logic signed [SW-1:0] value;
  logic                 last;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        count;
  logic                 dropped;
  logic [AW-1:0]        lo_idx, hi_idx;
  logic [QW-1:0]        frac;
  logic signed [SW-1:0] lo_val;
  logic [SW-1:0]        gap;
  logic [SW+QW-1:0]     prod;

  logic [FW-1:0]        p_clamp;
  logic [AW-1:0]        nm1;
  logic [PW-1:0]        posq;
  logic [AW-1:0]        lo_calc;
  logic [CW-1:0]        pos_dec;

  assign pos_dec = pos - CW'(1);
  assign p_clamp = (frac_cfg > pi_pkg::FRAC_ONE) ? pi_pkg::FRAC_ONE : frac_cfg;
  assign nm1     = AW'(count - CW'(1));
  assign posq    = PW'(nm1) * PW'(p_clamp);
  assign lo_calc = posq[QW +: AW];

  always_comb begin
    if (cmd.rd_prev)    rd_addr = pos_dec[AW-1:0];
    else if (cmd.rd_hi) rd_addr = hi_idx;
    else if (cmd.rd_lo) rd_addr = lo_idx;
    else                rd_addr = lo_idx;
    wr_en   = cmd.shift | cmd.place;
    wr_addr = pos[AW-1:0];
    wr_data = cmd.shift ? rd_data : value;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_cfg  <= pi_pkg::FRAC_RESET;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) frac_cfg <= cfg_wdata;
      if (cmd.drop) dropped <= 1'b1;
      if (cmd.place) count <= count + CW'(1);
      if (cmd.emit) begin
        out_valid <= 1'b1;
        count     <= '0;
        dropped   <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= in_value;
      last  <= in_last;
      pos   <= count;
    end
    if (cmd.shift) pos <= pos_dec;
    if (cmd.calc) begin
      lo_idx <= lo_calc;
      hi_idx <= (lo_calc == nm1) ? lo_calc : lo_calc + AW'(1);
      frac   <= posq[QW-1:0];
    end
    if (cmd.take_lo) lo_val <= rd_data;
    // sorted, so the unsigned difference is the true gap
    if (cmd.take_hi) gap <= rd_data - lo_val;
    if (cmd.mul) prod <= (SW+QW)'(gap) * (SW+QW)'(frac);
    if (cmd.emit) begin
      out_value <= lo_val + $signed(prod[QW +: SW]);
      out_used  <= count[pi_pkg::USED_W-1:0];
      out_ovf   <= dropped;
    end
  end

  always_comb begin
    sts.full     = (count == pi_pkg::CNT_FULL);
    sts.pos_zero = (pos == '0);
    sts.greater  = (rd_data > value);
    sts.last     = last;
    sts.out_busy = out_valid;
  end
endmodule
`default_nettype wire

>>> rtl/percentile_interpolated.sv
// Interpolated percentile over a streamed set of samples, kept sorted in a
// 1024-entry memory. Each sample walks down from the tail, moving greater entries
// up one place, then is written (separate memory read and write ports); a full
// store drops it. After the last sample is placed or dropped, states CALC, RDLO,
// RDHI, TAKEHI, MUL and EMIT form the result, later while the previous result waits.
// Synchronous reset empties the set, sets the fraction to one half; memory kept.
`default_nettype none
module percentile_interpolated (
  input  wire logic                       clk,
  input  wire logic                       rst,
  pi_sample_if.sink                       samples,
  pi_result_if.source                     result,
  input  wire logic                       cfg_we,
  input  wire logic [pi_pkg::FRAC_W-1:0]  cfg_wdata
);
  pi_pkg::cmd_t cmd;
  pi_pkg::sts_t sts;

  pi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_last  (samples.last_sample),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (samples.sample_value),
    .in_last   (samples.last_sample),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.percentile_value),
    .out_used  (result.samples_used),
    .out_ovf   (result.overflow_seen)
  );

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready |=> !result.valid)
    else $error("result repeated after transaction");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !(cmd.shift || cmd.place || cmd.emit))
    else $error("memory or result written while accepting");

  a_used_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.samples_used != '0)
    else $error("result with empty set");
endmodule
`default_nettype wire
